// ===== rtl/mhbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Header block parser package
// Payload types, byte classes, role and error codes shared by the parser.
// ----------------------------------------------------------------------------
package mhbp_pkg;

	localparam int unsigned LEN_OUT_W = 12;

	localparam logic [2:0] ROLE_NAME  = 3'd0;
	localparam logic [2:0] ROLE_GAP   = 3'd1;
	localparam logic [2:0] ROLE_VALUE = 3'd2;
	localparam logic [2:0] ROLE_EOL   = 3'd3;
	localparam logic [2:0] ROLE_AFTER = 3'd4;
	localparam logic [2:0] ROLE_NONE  = 3'd5;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CHAR     = 2'd1;
	localparam logic [1:0] ERR_HEADER   = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           byte_role;
		logic                 header_done;
		logic [LEN_OUT_W-1:0] name_len;
		logic [LEN_OUT_W-1:0] gap_len;
		logic [LEN_OUT_W-1:0] value_len;
		logic                 block_done;
		logic [1:0]           error_code;
	} out_item_t;

	typedef struct packed {
		logic is_colon;
		logic is_cr;
		logic is_lf;
		logic is_blank;
		logic is_token;
		logic is_ctl;
	} char_class_t;

endpackage : mhbp_pkg
`default_nettype wire

// ===== rtl/mhbp_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface mhbp_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface : mhbp_stream_if
`default_nettype wire

// ===== rtl/mime_header_block_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Header block parser core
// Parses a header block one byte per item, reporting roles, lengths and errors.
// ----------------------------------------------------------------------------
// Usage:
// Each item on in_chan carries one header byte and an end-of-stream flag.
// Each accepted item yields exactly one item on out_chan with the byte role,
// a header_done pulse with the finished header's name, gap and value
// lengths, the block_done level and the sticky error code.
// An item is taken into an input register, judged by the parser while it
// sits there and written to the result register. One item per cycle is
// sustained while out_chan does not stall; the rate is set by the parser
// step, which updates state and counters as each item moves on.
// When out_chan stalls, the result register holds and the input register
// fills; in_chan.ready falls only when both are full.
// Reset clears the pipeline valid bits, the parser state to the name state,
// the counters and the error code. A new header block needs a reset.
// Lengths are counted in LEN_BITS bits and reported in 12 bits.
// ----------------------------------------------------------------------------
module mime_header_block_parser_core
	import mhbp_pkg::*;
#(
	parameter int unsigned LEN_BITS = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mhbp_stream_if.sink   in_chan,
	mhbp_stream_if.source out_chan
);

	logic      v_s1, v_s2;
	in_item_t  item_s1;
	out_item_t res_s2;
	out_item_t res;
	logic      en_s1, en_s2, adv;

	assign en_s2 = !v_s2 || out_chan.ready;
	assign adv   = v_s1 && en_s2;
	assign en_s1 = !v_s1 || en_s2;

	assign in_chan.ready    = en_s1;
	assign out_chan.valid   = v_s2;
	assign out_chan.payload = res_s2;

	mhbp_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_chan.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_chan.valid) begin
			item_s1 <= in_chan.payload;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule : mime_header_block_parser_core
`default_nettype wire

// ===== rtl/mhbp_char_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte classifier
// Sorts one header byte into the classes the line parser needs.
// ----------------------------------------------------------------------------
module mhbp_char_class
	import mhbp_pkg::*;
(
	input  wire logic [7:0]  c,
	output char_class_t      cls
);

	logic alnum;
	logic mark;

	always_comb begin
		alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
		unique case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: mark = 1'b1;
			default: mark = 1'b0;
		endcase
		cls.is_colon = (c == CH_COLON);
		cls.is_cr    = (c == CH_CR);
		cls.is_lf    = (c == CH_LF);
		cls.is_blank = (c == CH_SPACE) || (c == CH_TAB);
		cls.is_token = alnum || mark;
		cls.is_ctl   = (c < CH_SPACE && c != CH_TAB) || (c == CH_DEL);
	end

endmodule : mhbp_char_class
`default_nettype wire

// ===== rtl/mhbp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Header line parser
// Parser state, length counters and sticky error, with the per-byte step.
// ----------------------------------------------------------------------------
module mhbp_parser
	import mhbp_pkg::*;
#(
	parameter int unsigned LEN_BITS = 12
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire in_item_t item,
	output out_item_t     res
);

	typedef enum logic [3:0] {
		ST_NAME     = 4'd0,
		ST_GAP      = 4'd1,
		ST_VALUE    = 4'd2,
		ST_CR       = 4'd3,
		ST_NEWLINE  = 4'd4,
		ST_FOLD     = 4'd5,
		ST_LASTLINE = 4'd6,
		ST_COMPLETE = 4'd7,
		ST_ERROR    = 4'd8
	} state_t;

	state_t              st_q, st_d;
	logic [LEN_BITS-1:0] name_q, gap_q, value_q;
	logic [LEN_BITS-1:0] name_d, gap_d, value_d;
	logic [1:0]          err_q, err_d;
	logic [2:0]          role;
	logic                hdone;
	logic [LEN_BITS-1:0] nl, gl, vl;
	logic [LEN_OUT_W-1:0] nl_o, gl_o, vl_o;
	char_class_t         cls;

	mhbp_char_class u_class (
		.c   (item.in_byte),
		.cls (cls)
	);

	always_comb begin
		st_d    = st_q;
		name_d  = name_q;
		gap_d   = gap_q;
		value_d = value_q;
		err_d   = err_q;
		role    = ROLE_NONE;
		hdone   = 1'b0;
		nl      = '0;
		gl      = '0;
		vl      = '0;
		if (st_q == ST_ERROR) begin
			st_d = ST_ERROR;
		end else if (item.end_of_stream) begin
			st_d = ST_COMPLETE;
		end else begin
			unique case (st_q)
				ST_NAME: begin
					if (cls.is_colon) begin
						if (name_q == '0) begin
							st_d  = ST_ERROR;
							err_d = ERR_HEADER;
						end else if (&gap_q) begin
							st_d  = ST_ERROR;
							err_d = ERR_OVERFLOW;
						end else begin
							gap_d = gap_q + 1'b1;
							st_d  = ST_GAP;
							role  = ROLE_GAP;
						end
					end else if (!cls.is_token) begin
						st_d  = ST_ERROR;
						err_d = ERR_CHAR;
					end else if (&name_q) begin
						st_d  = ST_ERROR;
						err_d = ERR_OVERFLOW;
					end else begin
						name_d = name_q + 1'b1;
						role   = ROLE_NAME;
					end
				end
				ST_GAP, ST_VALUE, ST_FOLD: begin
					if (cls.is_blank && st_q == ST_GAP) begin
						if (&gap_q) begin
							st_d  = ST_ERROR;
							err_d = ERR_OVERFLOW;
						end else begin
							gap_d = gap_q + 1'b1;
							role  = ROLE_GAP;
						end
					end else if (cls.is_blank) begin
						if (&value_q) begin
							st_d  = ST_ERROR;
							err_d = ERR_OVERFLOW;
						end else begin
							value_d = value_q + 1'b1;
							role    = ROLE_VALUE;
						end
					end else if (cls.is_lf) begin
						st_d = ST_NEWLINE;
						role = ROLE_EOL;
					end else if (cls.is_cr) begin
						st_d = ST_CR;
						role = ROLE_EOL;
					end else if (cls.is_ctl) begin
						st_d  = ST_ERROR;
						err_d = ERR_CHAR;
					end else if (&value_q) begin
						st_d  = ST_ERROR;
						err_d = ERR_OVERFLOW;
					end else begin
						value_d = value_q + 1'b1;
						st_d    = ST_VALUE;
						role    = ROLE_VALUE;
					end
				end
				ST_CR: begin
					if (cls.is_lf) begin
						st_d = ST_NEWLINE;
						role = ROLE_EOL;
					end else begin
						st_d  = ST_ERROR;
						err_d = ERR_HEADER;
					end
				end
				ST_LASTLINE: begin
					if (cls.is_lf) begin
						st_d = ST_COMPLETE;
						role = ROLE_EOL;
					end else begin
						st_d  = ST_ERROR;
						err_d = ERR_HEADER;
					end
				end
				ST_NEWLINE: begin
					if (cls.is_blank) begin
						if (&value_q) begin
							st_d  = ST_ERROR;
							err_d = ERR_OVERFLOW;
						end else begin
							value_d = value_q + 1'b1;
							st_d    = ST_FOLD;
							role    = ROLE_VALUE;
						end
					end else begin
						hdone   = 1'b1;
						nl      = name_q;
						gl      = gap_q;
						vl      = value_q;
						name_d  = '0;
						gap_d   = '0;
						value_d = '0;
						if (cls.is_lf) begin
							st_d = ST_COMPLETE;
							role = ROLE_EOL;
						end else if (cls.is_cr) begin
							st_d = ST_LASTLINE;
							role = ROLE_EOL;
						end else if (!cls.is_token) begin
							st_d  = ST_ERROR;
							err_d = ERR_CHAR;
						end else begin
							name_d = {{(LEN_BITS-1){1'b0}}, 1'b1};
							st_d   = ST_NAME;
							role   = ROLE_NAME;
						end
					end
				end
				ST_COMPLETE: begin
					role = ROLE_AFTER;
				end
				default: begin
					st_d = ST_ERROR;
				end
			endcase
		end
	end

	generate
		if (LEN_BITS >= LEN_OUT_W) begin : g_trunc
			assign nl_o = nl[LEN_OUT_W-1:0];
			assign gl_o = gl[LEN_OUT_W-1:0];
			assign vl_o = vl[LEN_OUT_W-1:0];
		end else begin : g_ext
			assign nl_o = {{(LEN_OUT_W-LEN_BITS){1'b0}}, nl};
			assign gl_o = {{(LEN_OUT_W-LEN_BITS){1'b0}}, gl};
			assign vl_o = {{(LEN_OUT_W-LEN_BITS){1'b0}}, vl};
		end
	endgenerate

	always_comb begin
		res.byte_role   = role;
		res.header_done = hdone;
		res.name_len    = nl_o;
		res.gap_len     = gl_o;
		res.value_len   = vl_o;
		res.block_done  = (st_d == ST_COMPLETE);
		res.error_code  = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_NAME;
			name_q  <= '0;
			gap_q   <= '0;
			value_q <= '0;
			err_q   <= ERR_NONE;
		end else if (adv) begin
			st_q    <= st_d;
			name_q  <= name_d;
			gap_q   <= gap_d;
			value_q <= value_d;
			err_q   <= err_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ERR_NONE |=> err_q == $past(err_q))
		else $error("error code changed after it was set");

	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ERROR) == (err_q != ERR_NONE))
		else $error("error state and error code disagree");

	a_after_role: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_q == ST_COMPLETE && !item.end_of_stream |-> role == ROLE_AFTER)
		else $error("byte after completion got a wrong role");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && hdone && !cls.is_token |=> name_q == '0 && gap_q == '0 && value_q == '0)
		else $error("counters not cleared after a finished header");

endmodule : mhbp_parser
`default_nettype wire
